/* src/cpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and constants of the command packet parser
// Byte codes of the packet framing, and the records that carry a finished
// field from the byte front end through the number conversion.
// ----------------------------------------------------------------------------
package cpp_pkg;

	localparam logic [7:0] BYTE_OPEN     = 8'h7B;
	localparam logic [7:0] BYTE_CLOSE    = 8'h7D;
	localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
	localparam logic [7:0] BYTE_RBRACKET = 8'h5D;
	localparam logic [7:0] BYTE_COLON    = 8'h3A;
	localparam logic [7:0] BYTE_COMMA    = 8'h2C;
	localparam logic [7:0] BYTE_QUOTE    = 8'h22;
	localparam logic [7:0] BYTE_PLUS     = 8'h2B;
	localparam logic [7:0] BYTE_MINUS    = 8'h2D;
	localparam logic [7:0] BYTE_POINT    = 8'h2E;
	localparam logic [7:0] BYTE_SPACE    = 8'h20;
	localparam logic [7:0] BYTE_TAB      = 8'h09;
	localparam logic [7:0] BYTE_CR       = 8'h0D;
	localparam logic [7:0] BYTE_ZERO     = 8'h30;
	localparam logic [7:0] BYTE_NINE     = 8'h39;

	// Field index width: up to eight values per packet.
	localparam int IDX_W = 3;
	// Integer part saturates at 65536, which needs 17 bits.
	localparam int INT_W = 17;
	localparam int FRAC_W = 17;
	localparam logic [INT_W-1:0] INT_CAP = 17'd65536;
	localparam int FRAC_DIGITS = 5;

	// A finished field as captured by the byte front end.
	typedef struct packed {
		logic              valid;
		logic              emit;
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [9:0]        ptype;
		logic [INT_W-1:0]  int_part;
		logic [FRAC_W-1:0] frac;
		logic [2:0]        fdig;
		logic              neg;
	} raw_t;

	// Fraction scaled to five decimal digits.
	typedef struct packed {
		logic              valid;
		logic              emit;
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [9:0]        ptype;
		logic [INT_W-1:0]  int_part;
		logic [FRAC_W-1:0] fscaled;
		logic              neg;
	} scl_t;

	// Fraction converted to sixteen binary places.
	typedef struct packed {
		logic              valid;
		logic              emit;
		logic              wr;
		logic [IDX_W-1:0]  idx;
		logic [9:0]        ptype;
		logic [INT_W-1:0]  int_part;
		logic [15:0]       qfrac;
		logic              neg;
	} cnv_t;

endpackage

/* src/cpp_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_conv: decimal fraction to binary fraction conversion
// Two pipeline stages: the fraction is scaled to five decimal digits, then
// multiplied by a reciprocal of 100000 / 65536 to give sixteen binary places.
// ----------------------------------------------------------------------------
module cpp_conv (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  cpp_pkg::raw_t fld,
	output cpp_pkg::cnv_t cnv
);

	// floor(f * 2048 / 3125) == (f * MUL) >> 31 for every f below 100000.
	localparam logic [30:0] MUL = 31'd1407374884;

	function automatic logic [13:0] pow10_fill(input logic [2:0] n);
		logic [13:0] p;
		unique case (n)
			3'd1:    p = 14'd10000;
			3'd2:    p = 14'd1000;
			3'd3:    p = 14'd100;
			3'd4:    p = 14'd10;
			3'd5:    p = 14'd1;
			default: p = 14'd0;
		endcase
		return p;
	endfunction

	cpp_pkg::scl_t scl_s2;
	cpp_pkg::cnv_t cnv_s3;
	logic [47:0]   prod;

	assign prod = 48'(scl_s2.fscaled) * 48'(MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_s2 <= '0;
			cnv_s3 <= '0;
		end else if (en) begin
			scl_s2.valid    <= fld.valid;
			scl_s2.emit     <= fld.emit;
			scl_s2.wr       <= fld.wr;
			scl_s2.idx      <= fld.idx;
			scl_s2.ptype    <= fld.ptype;
			scl_s2.int_part <= fld.int_part;
			scl_s2.neg      <= fld.neg;
			scl_s2.fscaled  <= cpp_pkg::FRAC_W'(fld.frac * pow10_fill(fld.fdig));

			cnv_s3.valid    <= scl_s2.valid;
			cnv_s3.emit     <= scl_s2.emit;
			cnv_s3.wr       <= scl_s2.wr;
			cnv_s3.idx      <= scl_s2.idx;
			cnv_s3.ptype    <= scl_s2.ptype;
			cnv_s3.int_part <= scl_s2.int_part;
			cnv_s3.neg      <= scl_s2.neg;
			cnv_s3.qfrac    <= prod[46:31];
		end
	end

	assign cnv = cnv_s3;

endmodule

/* src/command_packet_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_packet_parser: byte-serial parser for {"NNN":[v,v,v,v]} packets
// Recognises the packet header, collects the three-digit type and converts
// up to four comma-separated decimal numbers to signed Q16.16.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock cycle. The header bytes must
// arrive in order as an opening brace, a quote, three decimal digits, a
// quote, a colon and an opening bracket; any wrong header byte sends the
// parser back to idle and that byte is dropped. In the body, commas and
// closing brackets end a number, and a closing brace, or the byte that fills
// the body to BODY_MAX bytes, completes the packet. Each number is read like
// the C library atof: leading blanks, an optional sign, digits, an optional
// point and fraction; the first other character ends it, fraction digits past
// the fifth are ignored, and the value is truncated toward zero and saturated
// to the 32-bit range. Values that are missing or empty read as zero, and so
// do value slots at or above NUM_VALUES. After the byte that completes the
// packet, the result request is built step by step: the byte front end
// registers the finished number, two conversion stages scale the fraction and
// multiply by a reciprocal, and the last stage forms the saturated value into
// the output register. The block keeps taking one byte every cycle while a
// result waits on the output side; only when a second completed packet
// reaches the last conversion stage before the waiting result is taken does
// the input side hold, until the output register frees.
// ----------------------------------------------------------------------------
module command_packet_parser #(
	parameter int BODY_MAX   = 24,
	parameter int NUM_VALUES = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // [9:0] packet_type, [41:10] value_a,
	                                // [73:42] value_b, [105:74] value_c,
	                                // [137:106] value_d, [143:138] zero
);

	localparam int BL_W  = $clog2(BODY_MAX + 1);
	localparam int CNT_W = $clog2(NUM_VALUES + 1);
	localparam int IDX_W = cpp_pkg::IDX_W;
	localparam int INT_W = cpp_pkg::INT_W;
	localparam int FRAC_W = cpp_pkg::FRAC_W;

	// Frame position: idle, header bytes in order, then the body.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QUOTE1,
		ST_DIG0,
		ST_DIG1,
		ST_DIG2,
		ST_QUOTE2,
		ST_COLON,
		ST_LBRACKET,
		ST_BODY
	} state_t;

	state_t              state_q;
	logic [9:0]          type_q;
	logic [BL_W-1:0]     blen_q;
	logic [CNT_W-1:0]    fcnt_q;
	logic [INT_W-1:0]    int_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [2:0]          fdig_q;
	logic                neg_q;
	logic                point_q;
	logic                stop_q;
	logic                start_q;
	cpp_pkg::raw_t       raw_s1;

	// Flow control. The whole pipeline holds only when a completed packet
	// would land on a result that is still waiting.
	logic                en;
	logic                acc;
	cpp_pkg::cnv_t       cnv;

	assign en       = !(cnv.valid && cnv.emit && m_tvalid && !m_tready);
	assign s_tready = en;
	assign acc      = s_tvalid && en;

	// ------------------------------------------------------------------
	// Byte classification and the atof-style update of the field that is
	// being read.
	// ------------------------------------------------------------------
	logic [7:0]          rx;
	logic                is_digit;
	logic                is_blank;
	logic                is_close;
	logic                is_sep;
	logic [3:0]          dig;
	logic [19:0]         int_x10;
	logic [INT_W-1:0]    int_n;
	logic [FRAC_W-1:0]   frac_n;
	logic [2:0]          fdig_n;
	logic                neg_n;
	logic                point_n;
	logic                stop_n;
	logic                start_n;
	logic [BL_W-1:0]     blen_inc;
	logic                body_full;
	logic                finish;
	logic                emit_b;

	assign rx       = s_tdata;
	assign is_digit = (rx >= cpp_pkg::BYTE_ZERO) && (rx <= cpp_pkg::BYTE_NINE);
	assign is_blank = (rx == cpp_pkg::BYTE_SPACE)
		|| ((rx >= cpp_pkg::BYTE_TAB) && (rx <= cpp_pkg::BYTE_CR));
	assign is_close = (rx == cpp_pkg::BYTE_CLOSE);
	assign is_sep   = (rx == cpp_pkg::BYTE_COMMA) || (rx == cpp_pkg::BYTE_RBRACKET);
	assign dig      = rx[3:0];
	assign int_x10  = {int_q, 3'b000} + {2'b00, int_q, 1'b0} + 20'(dig);

	assign blen_inc  = blen_q + 1'b1;
	assign body_full = (blen_inc == BL_W'(BODY_MAX));
	assign finish    = is_close || is_sep || body_full;
	assign emit_b    = is_close || body_full;

	always_comb begin
		int_n   = int_q;
		frac_n  = frac_q;
		fdig_n  = fdig_q;
		neg_n   = neg_q;
		point_n = point_q;
		stop_n  = stop_q;
		start_n = start_q;
		// Separators and the closing brace are not fed to the number.
		if (!is_close && !is_sep && !stop_q && !(!start_q && is_blank)) begin
			priority if (!start_q && ((rx == cpp_pkg::BYTE_PLUS)
					|| (rx == cpp_pkg::BYTE_MINUS))) begin
				neg_n   = (rx == cpp_pkg::BYTE_MINUS);
				start_n = 1'b1;
			end else if (is_digit) begin
				start_n = 1'b1;
				if (!point_q) begin
					int_n = (int_x10 > 20'(cpp_pkg::INT_CAP)) ? cpp_pkg::INT_CAP
						: int_x10[INT_W-1:0];
				end else if (fdig_q < 3'(cpp_pkg::FRAC_DIGITS)) begin
					frac_n = FRAC_W'({frac_q, 3'b000} + {frac_q, 1'b0} + 20'(dig));
					fdig_n = fdig_q + 1'b1;
				end
			end else if ((rx == cpp_pkg::BYTE_POINT) && !point_q) begin
				point_n = 1'b1;
				start_n = 1'b1;
			end else begin
				stop_n = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Frame state and the register that hands a finished field on to the
	// conversion.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			type_q  <= '0;
			blen_q  <= '0;
			fcnt_q  <= '0;
			int_q   <= '0;
			frac_q  <= '0;
			fdig_q  <= '0;
			neg_q   <= 1'b0;
			point_q <= 1'b0;
			stop_q  <= 1'b0;
			start_q <= 1'b0;
			raw_s1  <= '0;
		end else begin
			if (en) begin
				raw_s1.valid    <= acc && (state_q == ST_BODY) && finish;
				raw_s1.emit     <= emit_b;
				raw_s1.wr       <= (fcnt_q < CNT_W'(NUM_VALUES));
				raw_s1.idx      <= IDX_W'(fcnt_q);
				raw_s1.ptype    <= type_q;
				raw_s1.int_part <= int_n;
				raw_s1.frac     <= frac_n;
				raw_s1.fdig     <= fdig_n;
				raw_s1.neg      <= neg_n;
			end
			if (acc) begin
				unique case (state_q)
					ST_IDLE: begin
						if (rx == cpp_pkg::BYTE_OPEN) begin
							state_q <= ST_QUOTE1;
							type_q  <= '0;
							blen_q  <= '0;
							fcnt_q  <= '0;
							int_q   <= '0;
							frac_q  <= '0;
							fdig_q  <= '0;
							neg_q   <= 1'b0;
							point_q <= 1'b0;
							stop_q  <= 1'b0;
							start_q <= 1'b0;
						end
					end
					ST_QUOTE1: begin
						state_q <= (rx == cpp_pkg::BYTE_QUOTE) ? ST_DIG0 : ST_IDLE;
					end
					ST_DIG0, ST_DIG1, ST_DIG2: begin
						if (is_digit) begin
							type_q  <= 10'({type_q, 3'b000} + {type_q, 1'b0} + 13'(dig));
							state_q <= state_t'(state_q + 1'b1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
					ST_QUOTE2: begin
						state_q <= (rx == cpp_pkg::BYTE_QUOTE) ? ST_COLON : ST_IDLE;
					end
					ST_COLON: begin
						state_q <= (rx == cpp_pkg::BYTE_COLON) ? ST_LBRACKET : ST_IDLE;
					end
					ST_LBRACKET: begin
						state_q <= (rx == cpp_pkg::BYTE_LBRACKET) ? ST_BODY : ST_IDLE;
					end
					ST_BODY: begin
						if (!is_close) begin
							blen_q <= blen_inc;
						end
						if (finish) begin
							if (fcnt_q < CNT_W'(NUM_VALUES)) begin
								fcnt_q <= fcnt_q + 1'b1;
							end
							int_q   <= '0;
							frac_q  <= '0;
							fdig_q  <= '0;
							neg_q   <= 1'b0;
							point_q <= 1'b0;
							stop_q  <= 1'b0;
							start_q <= 1'b0;
						end else begin
							int_q   <= int_n;
							frac_q  <= frac_n;
							fdig_q  <= fdig_n;
							neg_q   <= neg_n;
							point_q <= point_n;
							stop_q  <= stop_n;
							start_q <= start_n;
						end
						if (emit_b) begin
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Fraction conversion pipeline.
	// ------------------------------------------------------------------
	cpp_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.fld    (raw_s1),
		.cnv    (cnv)
	);

	// ------------------------------------------------------------------
	// Final value: the integer part and the sixteen fraction bits sit side
	// by side, so the magnitude needs no adder. Then sign and saturation.
	// ------------------------------------------------------------------
	logic [32:0] mag;
	logic [31:0] cval;

	assign mag = {cnv.int_part, cnv.qfrac};

	always_comb begin
		if (cnv.neg) begin
			cval = (mag > 33'h0_8000_0000) ? 32'h8000_0000
				: 32'(33'h1_0000_0000 - mag);
		end else begin
			cval = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
	end

	// Values of the finished fields of the packet in progress. A slot whose
	// valid bit is clear reads as zero; every completed packet clears them.
	logic [31:0]           val_q [NUM_VALUES];
	logic [NUM_VALUES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en && cnv.valid) begin
			if (cnv.emit) begin
				vld_q <= '0;
			end else if (cnv.wr) begin
				for (int k = 0; k < NUM_VALUES; k++) begin
					if (cnv.idx == IDX_W'(k)) begin
						vld_q[k] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && cnv.valid && !cnv.emit && cnv.wr) begin
			for (int k = 0; k < NUM_VALUES; k++) begin
				if (cnv.idx == IDX_W'(k)) begin
					val_q[k] <= cval;
				end
			end
		end
	end

	logic [31:0] res_val [4];

	for (genvar g = 0; g < 4; g++) begin : g_res
		if (g < NUM_VALUES) begin : g_on
			assign res_val[g] = (cnv.wr && (cnv.idx == IDX_W'(g))) ? cval
				: (vld_q[g] ? val_q[g] : 32'h0);
		end else begin : g_off
			assign res_val[g] = 32'h0;
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	logic         out_vld_q;
	logic [143:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en && cnv.valid && cnv.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && cnv.valid && cnv.emit) begin
			out_q <= {6'b0, res_val[3], res_val[2], res_val[1], res_val[0], cnv.ptype};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BODY) |-> (blen_q < BL_W'(BODY_MAX)))
		else $error("body length reached its limit without completing the packet");

	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CNT_W'(NUM_VALUES))
		else $error("field counter ran past the number of value slots");

	a_store_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cnv.valid && cnv.wr) |-> ({1'b0, cnv.idx} < (IDX_W + 1)'(NUM_VALUES)))
		else $error("value store written beyond its slots");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(en && cnv.valid && cnv.emit) |-> (!m_tvalid || m_tready))
		else $error("result overwrote a request still waiting");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (state_q == ST_BODY) && emit_b) |=> (state_q == ST_IDLE))
		else $error("parser did not return to idle after a completed packet");

endmodule
